### rtl/i2c_trf_pkg.sv
// Package: shared constants, command codes and control structs for the I2C target register file.
`timescale 1ns / 1ps

package i2c_trf_pkg;

  // Register file geometry
  localparam int FILE_DEPTH = 32;
  localparam int ADDR_W     = (FILE_DEPTH > 1) ? $clog2(FILE_DEPTH) : 1;

  // Field widths
  localparam int CMD_W   = 4;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 9;

  localparam logic [COUNT_W-1:0] REG_COUNT_RESET = 9'd32;

  // Bus events and local commands
  localparam logic [CMD_W-1:0] CMD_WRITE_SELECT = 4'd0;
  localparam logic [CMD_W-1:0] CMD_RX_ACK       = 4'd1;
  localparam logic [CMD_W-1:0] CMD_RX_NACK      = 4'd2;
  localparam logic [CMD_W-1:0] CMD_TX_BYTE      = 4'd3;
  localparam logic [CMD_W-1:0] CMD_TX_END       = 4'd4;
  localparam logic [CMD_W-1:0] CMD_STOP         = 4'd5;
  localparam logic [CMD_W-1:0] CMD_BUS_ERROR    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_LOCAL_READ   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_LOCAL_WRITE  = 4'd8;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the request and launch the file read
    logic commit;   // update state, write the file, load the result register
  } ctrl_cmd_t;

endpackage

### rtl/i2c_trf_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module i2c_trf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/i2c_trf_ctrl.sv
// Controller: sequences capture and commit of one request and owns the result valid flag.
`timescale 1ns / 1ps

module i2c_trf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output i2c_trf_pkg::ctrl_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;
  logic   slot_free;

  assign in_ready    = (state == ST_IDLE);
  assign slot_free   = !out_valid || out_ready;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.commit  = (state == ST_EXEC) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.capture) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/i2c_trf_dp.sv
// Datapath: pointer, phase and acknowledge state, register file with valid bits, result register.
`timescale 1ns / 1ps

module i2c_trf_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  i2c_trf_pkg::ctrl_cmd_t               cmd,
  input  logic [i2c_trf_pkg::CMD_W-1:0]        in_command,
  input  logic [i2c_trf_pkg::BYTE_W-1:0]       in_data_byte,
  input  logic [i2c_trf_pkg::BYTE_W-1:0]       in_local_index,
  input  logic                                 cfg_write,
  input  logic [i2c_trf_pkg::COUNT_W-1:0]      cfg_count,
  output logic [i2c_trf_pkg::BYTE_W-1:0]       transmit_byte,
  output logic                                 ack_next,
  output logic                                 release_bus,
  output logic [i2c_trf_pkg::BYTE_W-1:0]       local_read_data,
  output logic [i2c_trf_pkg::BYTE_W-1:0]       pointer_now
);

  localparam int BW = i2c_trf_pkg::BYTE_W;
  localparam int AW = i2c_trf_pkg::ADDR_W;
  localparam int CW = i2c_trf_pkg::COUNT_W;

  // Architectural state
  logic [CW-1:0] register_count;
  logic [BW-1:0] register_pointer;
  logic          expect_data_phase;
  logic          ack_enable;
  logic [i2c_trf_pkg::FILE_DEPTH-1:0] valid;

  // Captured request
  logic [i2c_trf_pkg::CMD_W-1:0] req_cmd;
  logic [BW-1:0]                 req_data;
  logic [BW-1:0]                 req_lidx;
  logic [BW-1:0]                 rd_idx;

  logic [BW-1:0] read_idx_next;
  logic [BW-1:0] ram_q;
  logic [BW-1:0] read_byte;
  logic          rd_in_range;

  logic [BW-1:0] register_pointer_next;
  logic          expect_data_phase_next;
  logic          ack_enable_next;
  logic [BW-1:0] tx_next;
  logic [BW-1:0] lrd_next;
  logic          rel_next;
  logic          store;
  logic [BW-1:0] wr_idx;
  logic          wr_in_range;
  logic          we;
  logic [BW-1:0] ptr_inc;

  function automatic logic idx_ok(input logic [BW-1:0] idx, input logic [CW-1:0] count);
    logic [CW-1:0] wide;
    wide   = {1'b0, idx};
    idx_ok = (wide < count) && (wide < CW'(i2c_trf_pkg::FILE_DEPTH));
  endfunction

  // Read address: local read uses its own index, everything else the pointer
  assign read_idx_next = (in_command == i2c_trf_pkg::CMD_LOCAL_READ) ? in_local_index
                                                                      : register_pointer;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_cmd  <= in_command;
      req_data <= in_data_byte;
      req_lidx <= in_local_index;
      rd_idx   <= read_idx_next;
    end
  end

  // Never-written entries read as zero; out-of-range reads too
  assign rd_in_range = idx_ok(rd_idx, register_count);
  assign read_byte   = (rd_in_range && valid[rd_idx[AW-1:0]]) ? ram_q : '0;
  assign ptr_inc     = register_pointer + 8'd1;

  always_comb begin
    register_pointer_next  = register_pointer;
    expect_data_phase_next = expect_data_phase;
    ack_enable_next        = ack_enable;
    tx_next                = '0;
    lrd_next               = '0;
    rel_next               = 1'b0;
    store                  = 1'b0;
    wr_idx                 = register_pointer;
    case (req_cmd)
      i2c_trf_pkg::CMD_WRITE_SELECT,
      i2c_trf_pkg::CMD_TX_END: begin
        expect_data_phase_next = 1'b0;
        register_pointer_next  = '0;
        ack_enable_next        = 1'b1;
      end
      i2c_trf_pkg::CMD_RX_ACK: begin
        if (!expect_data_phase) begin
          expect_data_phase_next = 1'b1;
          register_pointer_next  = req_data;
          ack_enable_next        = 1'b1;
        end else begin
          store                 = 1'b1;
          register_pointer_next = ptr_inc;
          ack_enable_next       = (({1'b0, ptr_inc} + 9'd1) < register_count);
        end
      end
      i2c_trf_pkg::CMD_RX_NACK: begin
        store                  = 1'b1;
        expect_data_phase_next = 1'b0;
        register_pointer_next  = '0;
        ack_enable_next        = 1'b1;
      end
      i2c_trf_pkg::CMD_TX_BYTE: begin
        tx_next               = read_byte;
        register_pointer_next = ptr_inc;
        ack_enable_next       = ({1'b0, ptr_inc} < register_count);
      end
      i2c_trf_pkg::CMD_STOP: begin
        expect_data_phase_next = 1'b0;
        ack_enable_next        = 1'b1;
      end
      i2c_trf_pkg::CMD_LOCAL_READ: begin
        lrd_next = read_byte;
      end
      i2c_trf_pkg::CMD_LOCAL_WRITE: begin
        store  = 1'b1;
        wr_idx = req_lidx;
      end
      default: begin  // bus error and unused codes
        expect_data_phase_next = 1'b0;
        register_pointer_next  = '0;
        ack_enable_next        = 1'b1;
        rel_next               = 1'b1;
      end
    endcase
  end

  assign wr_in_range = idx_ok(wr_idx, register_count);
  assign we          = cmd.commit && store && wr_in_range;

  i2c_trf_ram #(
    .WIDTH (BW),
    .DEPTH (i2c_trf_pkg::FILE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_idx[AW-1:0]),
    .wdata (req_data),
    .re    (cmd.capture),
    .raddr (read_idx_next[AW-1:0]),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      register_count    <= i2c_trf_pkg::REG_COUNT_RESET;
      register_pointer  <= '0;
      expect_data_phase <= 1'b0;
      ack_enable        <= 1'b1;
      valid             <= '0;
    end else begin
      if (cfg_write) begin
        register_count <= cfg_count;
      end
      if (cmd.commit) begin
        register_pointer  <= register_pointer_next;
        expect_data_phase <= expect_data_phase_next;
        ack_enable        <= ack_enable_next;
      end
      if (we) begin
        valid[wr_idx[AW-1:0]] <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      transmit_byte   <= tx_next;
      ack_next        <= ack_enable_next;
      release_bus     <= rel_next;
      local_read_data <= lrd_next;
      pointer_now     <= register_pointer_next;
    end
  end

endmodule

### rtl/i2c_target_register_file_core.sv
// Top level: I2C target register file core with stream request/result channels.
`timescale 1ns / 1ps

//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser: command; tdata: data_byte, local_index
//  m_      | out | m_tvalid/m_tready  | tdata: transmit_byte, ack_next, release_bus,
//          |     |                    |        local_read_data, pointer_now
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_data: register_count
//
//  Each request runs as capture (launch file read), then commit, which uses the
//  registered read of the register file RAM. One result per request.
//  The result register decouples the sides: a new request is taken while the
//  previous result waits; commit stalls only while that result is still unread.
//  rst is synchronous: pointer 0, pointer-byte phase, ACK enabled, count 32 and
//  all file entries read as zero until written (per-entry valid bits).
//  cfg writes are always accepted (cfg_ready high).

module i2c_target_register_file_core (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] data_byte, [15:8] local_index
  input  logic [3:0]  s_tuser,   // [3:0] command
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] transmit_byte, [8] ack_next, [9] release_bus,
                                 // [17:10] local_read_data, [25:18] pointer_now, rest 0
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data   // register_count
);

  i2c_trf_pkg::ctrl_cmd_t cmd;

  logic [7:0] transmit_byte;
  logic       ack_next;
  logic       release_bus;
  logic [7:0] local_read_data;
  logic [7:0] pointer_now;

  assign cfg_ready = 1'b1;

  i2c_trf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  i2c_trf_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .in_command      (s_tuser),
    .in_data_byte    (s_tdata[7:0]),
    .in_local_index  (s_tdata[15:8]),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_count       (cfg_data),
    .transmit_byte   (transmit_byte),
    .ack_next        (ack_next),
    .release_bus     (release_bus),
    .local_read_data (local_read_data),
    .pointer_now     (pointer_now)
  );

  assign m_tdata = {6'd0, pointer_now, local_read_data, release_bus, ack_next, transmit_byte};

endmodule
